### hw/rtl/escaped_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// Escaped frame receiver assertion macros
// Concurrent check wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define EFR_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("check failed: %m");
`define EFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: %m");
`else
`define EFR_ASSERT_ALWAYS(lbl, cond)
`define EFR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/efr_pkg.sv
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Link byte codes, status codes and the shared frame state type.
// ----------------------------------------------------------------------------
package efr_pkg;

    localparam logic [7:0] BYTE_HDR = 8'hFF;
    localparam logic [7:0] BYTE_EOF = 8'hFE;
    localparam logic [7:0] BYTE_ESC = 8'hFD;
    localparam logic [7:0] ESC_FF   = 8'h00;
    localparam logic [7:0] ESC_FE   = 8'h01;
    localparam logic [7:0] ESC_FD   = 8'h02;

    // counters only need to resolve values up to the offsets below
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] MIN_RAW_LEN  = CNT_W'(40);
    localparam logic [CNT_W-1:0] OFS_LEN_LO   = CNT_W'(36);
    localparam logic [CNT_W-1:0] OFS_LEN_HI   = CNT_W'(37);
    localparam logic [CNT_W-1:0] OFS_PAY_EMIT = CNT_W'(39);

    localparam int LEN_W  = 16;
    localparam int EMIT_W = 15;

    typedef enum logic
    {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef enum logic [2:0]
    {
        ST_OK            = 3'd0,
        ST_SHORT         = 3'd1,
        ST_BAD_ESC       = 3'd2,
        ST_BAD_SUM       = 3'd3,
        ST_PAYLOAD_SHORT = 3'd4
    } status_t;

    typedef struct packed
    {
        logic              in_frame;
        logic              esc_pending;
        logic              esc_error;
        logic [CNT_W-1:0]  raw_cnt;
        logic [CNT_W-1:0]  dec_idx;
        logic [7:0]        xor_sum;
        logic [7:0]        held_byte;
        logic              held_valid;
        logic [LEN_W-1:0]  length;
        logic [EMIT_W-1:0] emitted;
    } frame_state_t;

    typedef struct packed
    {
        logic       valid;
        kind_t      kind;
        logic [7:0] payload_byte;
        status_t    frame_status;
    } result_t;

endpackage

### hw/rtl/efr_step.sv
// ----------------------------------------------------------------------------
// Escaped frame receiver step logic
// Next frame state and optional result for one raw link byte.
// ----------------------------------------------------------------------------
module efr_step
(
    input  efr_pkg::frame_state_t state,
    input  logic [7:0]            raw_byte,
    output efr_pkg::frame_state_t state_next,
    output efr_pkg::result_t      result
);

    logic                        take_en;
    logic [7:0]                  take_byte;
    logic [efr_pkg::CNT_W-1:0]   raw_inc;
    logic [efr_pkg::EMIT_W-1:0]  limit;

    always_comb
    begin
        raw_inc = (state.raw_cnt == '1) ? state.raw_cnt : state.raw_cnt + 1'b1;
        limit   = state.length[efr_pkg::LEN_W-1] ? '0 : state.length[efr_pkg::EMIT_W-1:0];
    end

    always_comb
    begin
        state_next          = state;
        result.valid        = 1'b0;
        result.kind         = efr_pkg::KIND_PAYLOAD;
        result.payload_byte = 8'h00;
        result.frame_status = efr_pkg::ST_OK;
        take_en             = 1'b0;
        take_byte           = raw_byte;

        if (raw_byte == efr_pkg::BYTE_HDR)
        begin
            state_next          = '0;
            state_next.in_frame = 1'b1;
            state_next.raw_cnt  = efr_pkg::CNT_W'(1);
            state_next.dec_idx  = efr_pkg::CNT_W'(1);
        end
        else if (state.in_frame)
        begin
            state_next.raw_cnt = raw_inc;
            if (raw_byte == efr_pkg::BYTE_EOF)
            begin
                result.valid = 1'b1;
                result.kind  = efr_pkg::KIND_STATUS;
                if (raw_inc < efr_pkg::MIN_RAW_LEN)
                    result.frame_status = efr_pkg::ST_SHORT;
                else if (state.esc_error || state.esc_pending)
                    result.frame_status = efr_pkg::ST_BAD_ESC;
                else if (state.xor_sum != 8'h00)
                    result.frame_status = efr_pkg::ST_BAD_SUM;
                else if (state.dec_idx < efr_pkg::OFS_PAY_EMIT || state.emitted < limit)
                    result.frame_status = efr_pkg::ST_PAYLOAD_SHORT;
                else
                    result.frame_status = efr_pkg::ST_OK;
                state_next = '0;
            end
            else if (!state.esc_error)
            begin
                if (state.esc_pending)
                begin
                    state_next.esc_pending = 1'b0;
                    case (raw_byte)
                        efr_pkg::ESC_FF: begin take_en = 1'b1; take_byte = 8'hFF; end
                        efr_pkg::ESC_FE: begin take_en = 1'b1; take_byte = 8'hFE; end
                        efr_pkg::ESC_FD: begin take_en = 1'b1; take_byte = 8'hFD; end
                        default:         state_next.esc_error = 1'b1;
                    endcase
                end
                else if (raw_byte == efr_pkg::BYTE_ESC)
                    state_next.esc_pending = 1'b1;
                else
                    take_en = 1'b1;
            end
        end

        if (take_en)
        begin
            if (state.dec_idx == efr_pkg::OFS_LEN_LO)
                state_next.length[7:0] = take_byte;
            else if (state.dec_idx == efr_pkg::OFS_LEN_HI)
                state_next.length[15:8] = take_byte;
            state_next.xor_sum = state.xor_sum ^ take_byte;
            if (state.held_valid && state.dec_idx >= efr_pkg::OFS_PAY_EMIT
                && state.emitted < limit)
            begin
                result.valid        = 1'b1;
                result.kind         = efr_pkg::KIND_PAYLOAD;
                result.payload_byte = state.held_byte;
                state_next.emitted  = state.emitted + 1'b1;
            end
            state_next.held_byte  = take_byte;
            state_next.held_valid = 1'b1;
            state_next.dec_idx    = (state.dec_idx == '1) ? state.dec_idx
                                                          : state.dec_idx + 1'b1;
        end
    end

endmodule

### hw/rtl/escaped_frame_receiver.sv
// ----------------------------------------------------------------------------
// Escaped frame receiver
// Byte-stuffed frame deframer with XOR checksum and length-limited payload.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one raw link byte per beat. 0xFF opens (or restarts) a frame,
//   0xFE closes it, 0xFD escapes the following byte.
//   m_* carries results: tuser low = payload byte beat (tdata[7:0]), tuser
//   high = frame status beat (tdata[10:8]), the last beat of a frame.
//   Payload bytes leave one decoded byte late and are tentative until the
//   status beat reports ok.
//   Timing: a result is registered and is visible in the cycle after the
//   input beat that causes it is accepted. Throughput: one input beat per
//   cycle while s_tready is high; each raw byte is decoded in the same cycle
//   against the frame state register and lands in the output register.
//   Stall: s_tready drops only while a result waits in the output register
//   and m_tready is low; an empty or draining output register never stalls.
//   Reset: clears the frame state and the output register; the block waits
//   for 0xFF.
// ----------------------------------------------------------------------------
`include "escaped_frame_receiver_defines.svh"

module escaped_frame_receiver
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] raw_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [10:8] frame_status, rest zero
    output logic        m_tuser    // [0] kind
);

    efr_pkg::frame_state_t state_reg;
    efr_pkg::frame_state_t state_next;
    efr_pkg::result_t      res;
    efr_pkg::result_t      out_reg;
    logic                  s_acc;
    logic [efr_pkg::EMIT_W-1:0] limit;

    efr_step u_step
    (
        .state      (state_reg),
        .raw_byte   (s_tdata),
        .state_next (state_next),
        .result     (res)
    );

    assign s_tready = !out_reg.valid || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            out_reg   <= '0;
        end
        else
        begin
            if (s_acc)
            begin
                state_reg <= state_next;
                out_reg   <= res;
            end
            else if (m_tready)
                out_reg.valid <= 1'b0;
        end
    end

    assign m_tvalid = out_reg.valid;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {5'b0, out_reg.frame_status, out_reg.payload_byte};

    assign limit = state_reg.length[efr_pkg::LEN_W-1] ? '0
                 : state_reg.length[efr_pkg::EMIT_W-1:0];

    `EFR_ASSERT_ALWAYS(a_esc_exclusive, !(state_reg.esc_pending && state_reg.esc_error))
    `EFR_ASSERT_ALWAYS(a_emit_bounded, state_reg.emitted <= limit)
    `EFR_ASSERT_ALWAYS(a_idle_clear,
        state_reg.in_frame || (state_reg.raw_cnt == '0 && state_reg.xor_sum == 8'h00))
    `EFR_ASSERT_NEXT(a_eof_status,
        s_acc && state_reg.in_frame && s_tdata == efr_pkg::BYTE_EOF,
        !state_reg.in_frame && m_tvalid && m_tuser == efr_pkg::KIND_STATUS)

endmodule
